>>> rtl/lz4d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 block decoder package
// Shared constants, error codes and the control word passed from the parser
// to the output stage.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  // Default history depth, also the largest block the decoder accepts
  localparam int LZ4D_BLOCK_BYTES = 4096;

  // Token nibble and extension byte that announce more length bytes
  localparam logic [3:0] NIB_EXT   = 4'hF;
  localparam logic [7:0] BYTE_EXT  = 8'hFF;
  // Shortest match encoded by a zero match nibble
  localparam int         MATCH_MIN = 4;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_BUSY      = 2'd2
  } err_t;

  // Decode of one accepted item
  typedef struct packed {
    logic res;       // item produces a result
    logic dv;        // result carries a byte
    logic lit;       // byte is the incoming literal
    logic from_mem;  // byte comes from the history store
    logic done;      // block ends with this item
    err_t err;       // status when done
    logic pend;      // match bytes remain after this item
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/lz4d_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 decoder channels
// Valid/ready channels for compressed input items and decoded result items.
// ----------------------------------------------------------------------------
interface lz4d_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  in_byte;
  logic        last_byte;
  logic [12:0] block_out_size;

  modport source (output valid, action, in_byte, last_byte, block_out_size, input ready);
  modport sink   (input valid, action, in_byte, last_byte, block_out_size, output ready);
endinterface

interface lz4d_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] out_data;
  logic       block_done;
  logic [1:0] error_code;
  logic       copy_pending;

  modport source (output valid, data_valid, out_data, block_done, error_code, copy_pending,
                  input ready);
  modport sink   (input valid, data_valid, out_data, block_done, error_code, copy_pending,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/lz4d_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 decoder history store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lz4d_hist #(
  parameter int   BLOCK_BYTES = lz4d_pkg::LZ4D_BLOCK_BYTES,
  localparam int  AW          = $clog2(BLOCK_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [BLOCK_BYTES];

  // Store decoded bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a match source byte; hold it until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/lz4d_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 decoder stream parser
// Walks token, length extensions, literals, offset and match copy for each
// accepted item and keeps the block state.
// ----------------------------------------------------------------------------
module lz4d_parse #(
  parameter int   BLOCK_BYTES = lz4d_pkg::LZ4D_BLOCK_BYTES,
  localparam int  AW          = $clog2(BLOCK_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic          action,
  input  wire logic [7:0]    in_byte,
  input  wire logic          last_byte,
  input  wire logic [12:0]   block_out_size,
  output lz4d_pkg::ctl_t     ctl,
  output logic      [AW-1:0] rd_addr,
  output logic      [AW-1:0] wr_addr
);

  import lz4d_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam int LW = $clog2(BLOCK_BYTES + 2);
  localparam int XW = LW + 9;
  localparam int OW = (CW > 16) ? CW : 16;
  localparam int BW = (CW > 13) ? CW : 13;
  localparam logic [LW-1:0] LEN_CAP  = LW'(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] MAX_SIZE = CW'(BLOCK_BYTES);

  typedef enum logic [7:0] {
    PH_TOKEN   = 8'b0000_0001,
    PH_LITLEN  = 8'b0000_0010,
    PH_LIT     = 8'b0000_0100,
    PH_OFFLO   = 8'b0000_1000,
    PH_OFFHI   = 8'b0001_0000,
    PH_MATLEN  = 8'b0010_0000,
    PH_COPY    = 8'b0100_0000,
    PH_COPYEND = 8'b1000_0000
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] exp_r, exp_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0]    nib_r, nib_nxt;
  logic [15:0]   off_r, off_nxt;
  logic          failed_r, failed_nxt;

  logic [CW-1:0] room;
  logic [XW-1:0] sum;
  logic [15:0]   off_full;
  logic          lit_after, mat_after;
  logic          fin, abrt;
  err_t          abrt_err;

  // Decode the item against the current phase
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    exp_nxt    = exp_r;
    len_nxt    = len_r;
    nib_nxt    = nib_r;
    off_nxt    = off_r;
    failed_nxt = failed_r;
    ctl        = '0;
    room       = '0;
    sum        = '0;
    off_full   = '0;
    lit_after  = 1'b0;
    mat_after  = 1'b0;
    fin        = 1'b0;
    abrt       = 1'b0;
    abrt_err   = ERR_MALFORMED;
    rd_addr    = AW'(OW'(cnt_r) - OW'(off_r));
    wr_addr    = AW'(cnt_r);

    if (failed_r) begin
      // Drop everything up to the block's last byte
      if (!action && last_byte) begin
        failed_nxt = 1'b0;
      end
    end else if (action) begin
      // Copy one match byte
      if (phase_r == PH_COPY || phase_r == PH_COPYEND) begin
        ctl.dv       = 1'b1;
        ctl.from_mem = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        len_nxt      = len_r - 1'b1;
        if (len_nxt == '0) begin
          if (phase_r == PH_COPYEND) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
    end else begin
      case (phase_r)
        PH_TOKEN: begin
          if (cnt_r == '0) begin
            exp_nxt = (BW'(block_out_size) > BW'(BLOCK_BYTES)) ? MAX_SIZE
                                                                : CW'(block_out_size);
          end
          nib_nxt = in_byte[3:0];
          len_nxt = LW'(in_byte[7:4]);
          if (in_byte[7:4] == NIB_EXT) begin
            if (last_byte) begin
              fin  = 1'b1;
              abrt = 1'b1;
            end else begin
              phase_nxt = PH_LITLEN;
            end
          end else begin
            lit_after = 1'b1;
          end
        end
        PH_LITLEN: begin
          sum     = XW'(len_r) + XW'(in_byte);
          len_nxt = (sum > XW'(LEN_CAP)) ? LEN_CAP : LW'(sum);
          if (in_byte == BYTE_EXT) begin
            if (last_byte) begin
              fin  = 1'b1;
              abrt = 1'b1;
            end
          end else begin
            lit_after = 1'b1;
          end
        end
        PH_LIT: begin
          ctl.dv  = 1'b1;
          ctl.lit = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          len_nxt = len_r - 1'b1;
          if (len_nxt == '0) begin
            if (last_byte) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_OFFLO;
            end
          end else if (last_byte) begin
            fin  = 1'b1;
            abrt = 1'b1;
          end
        end
        PH_OFFLO: begin
          off_nxt = {8'h00, in_byte};
          if (last_byte) begin
            fin  = 1'b1;
            abrt = 1'b1;
          end else begin
            phase_nxt = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          off_full = {in_byte, off_r[7:0]};
          off_nxt  = off_full;
          if (off_full == '0 || OW'(off_full) > OW'(cnt_r)) begin
            fin  = 1'b1;
            abrt = 1'b1;
          end else if (nib_r == NIB_EXT) begin
            len_nxt = LW'(NIB_EXT);
            if (last_byte) begin
              fin  = 1'b1;
              abrt = 1'b1;
            end else begin
              phase_nxt = PH_MATLEN;
            end
          end else begin
            len_nxt   = LW'(nib_r);
            mat_after = 1'b1;
          end
        end
        PH_MATLEN: begin
          sum     = XW'(len_r) + XW'(in_byte);
          len_nxt = (sum > XW'(LEN_CAP)) ? LEN_CAP : LW'(sum);
          if (in_byte == BYTE_EXT) begin
            if (last_byte) begin
              fin  = 1'b1;
              abrt = 1'b1;
            end
          end else begin
            mat_after = 1'b1;
          end
        end
        default: begin
          // Compressed byte while a copy is still pending
          fin      = 1'b1;
          abrt     = 1'b1;
          abrt_err = ERR_BUSY;
        end
      endcase
    end

    room = exp_nxt - cnt_nxt;

    // Literal length settled: check room, then literals, offset or block end
    if (lit_after) begin
      if (XW'(len_nxt) > XW'(room)) begin
        fin  = 1'b1;
        abrt = 1'b1;
      end else if (len_nxt != '0) begin
        if (last_byte) begin
          fin  = 1'b1;
          abrt = 1'b1;
        end else begin
          phase_nxt = PH_LIT;
        end
      end else if (last_byte) begin
        fin = 1'b1;
      end else begin
        phase_nxt = PH_OFFLO;
      end
    end

    // Match length settled: check room, then arm the copy
    if (mat_after) begin
      sum = XW'(len_nxt) + XW'(MATCH_MIN);
      if (sum > XW'(room)) begin
        fin  = 1'b1;
        abrt = 1'b1;
      end else begin
        len_nxt   = LW'(sum);
        phase_nxt = last_byte ? PH_COPYEND : PH_COPY;
        ctl.res   = 1'b1;
      end
    end

    // Close the block
    if (fin) begin
      ctl.done  = 1'b1;
      ctl.err   = abrt ? abrt_err : ((cnt_nxt == exp_nxt) ? ERR_OK : ERR_MALFORMED);
      phase_nxt = PH_TOKEN;
      cnt_nxt   = '0;
      len_nxt   = '0;
      if (abrt && !last_byte) begin
        failed_nxt = 1'b1;
      end
    end

    ctl.res  = ctl.res | ctl.dv | ctl.done;
    ctl.pend = !failed_nxt && (phase_nxt == PH_COPY || phase_nxt == PH_COPYEND);
  end

  // Advance block state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TOKEN;
      cnt_r    <= '0;
      exp_r    <= '0;
      len_r    <= '0;
      nib_r    <= '0;
      off_r    <= '0;
      failed_r <= 1'b0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      exp_r    <= exp_nxt;
      len_r    <= len_nxt;
      nib_r    <= nib_nxt;
      off_r    <= off_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lz4_block_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 block decoder
// Takes one compressed byte or one copy tick per item and returns decoded
// bytes, match setup and end-of-block status.
// ----------------------------------------------------------------------------
// The decoder accepts one item every clock cycle while the result side keeps
// up; a result appears on the output register the cycle after its item is
// taken, and a stalled result holds the input side only for as long as it
// waits. Decoded bytes go into a BLOCK_BYTES-deep history RAM with a registered
// read; a byte is written as its result leaves, and a copy tick
// whose source is that same byte (offset of one) takes it from a bypass
// register instead of the RAM. The RAM needs no clearing after reset: the
// offset check keeps every read within bytes already written in the block.
module lz4_block_decoder #(
  parameter int BLOCK_BYTES = lz4d_pkg::LZ4D_BLOCK_BYTES
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lz4d_in_if.sink    in_ch,
  lz4d_out_if.source out_ch
);

  import lz4d_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);

  ctl_t          ctl;
  logic          acc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic          fwd;
  logic [7:0]    byte_cur;

  logic          s1_v_r, s1_v_nxt;
  logic          dv_r;
  logic          done_r;
  err_t          err_r;
  logic          pend_r;
  logic          use_hold_r;
  logic [7:0]    hold_r;
  logic [AW-1:0] wr_addr_r;

  assign in_ch.ready = !s1_v_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  lz4d_parse #(.BLOCK_BYTES(BLOCK_BYTES)) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .action         (in_ch.action),
    .in_byte        (in_ch.in_byte),
    .last_byte      (in_ch.last_byte),
    .block_out_size (in_ch.block_out_size),
    .ctl            (ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr)
  );

  lz4d_hist #(.BLOCK_BYTES(BLOCK_BYTES)) u_hist (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr_r),
    .wr_data   (byte_cur),
    .rd_en     (acc && ctl.from_mem),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Select the result byte; write it to history as the result leaves
  assign byte_cur = use_hold_r ? hold_r : rd_data;
  assign wr_en    = s1_v_r && dv_r && out_ch.ready;
  // Bypass the RAM when the read hits the byte being written this edge
  assign fwd      = wr_en && (wr_addr_r == rd_addr);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = ctl.res;
    end else if (out_ch.ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  // Hold the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      dv_r       <= ctl.dv;
      done_r     <= ctl.done;
      err_r      <= ctl.err;
      pend_r     <= ctl.pend;
      use_hold_r <= ctl.lit || (ctl.from_mem && fwd);
      hold_r     <= ctl.lit ? in_ch.in_byte : byte_cur;
      wr_addr_r  <= wr_addr;
    end
  end

  assign out_ch.valid        = s1_v_r;
  assign out_ch.data_valid   = dv_r;
  assign out_ch.out_data     = dv_r ? byte_cur : 8'h00;
  assign out_ch.block_done   = done_r;
  assign out_ch.error_code   = err_r;
  assign out_ch.copy_pending = pend_r;

  // An error code only comes with the end of a block
  a_err_with_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.error_code != ERR_OK) |-> out_ch.block_done)
    else $error("error code without block end");

  // A finished block leaves no copy pending
  a_done_no_pend : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.block_done |-> !out_ch.copy_pending)
    else $error("copy pending at block end");

  // Input stalls only behind a waiting result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a waiting result");

endmodule
`default_nettype wire

>>> tb/lz4d_tb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 block decoder testbench package
// Item and result types plus a cycle-free model of the decoder that turns
// every accepted item into the results the block must return, and checks
// the returned results against them in order.
// ----------------------------------------------------------------------------
package lz4d_tb_pkg;
  import lz4d_pkg::*;

  localparam int unsigned HIST_BYTES = LZ4D_BLOCK_BYTES;
  localparam int unsigned MAX_REPORTS = 20;

  typedef enum logic [2:0] {
    ST_TOKEN,
    ST_LITLEN,
    ST_LIT,
    ST_OFFLO,
    ST_OFFHI,
    ST_MATLEN,
    ST_COPY,
    ST_COPYEND
  } dec_state_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  data;
    logic        last;
    logic [12:0] bsz;
  } lz_item_t;

  typedef struct packed {
    logic       dv;
    logic [7:0] data;
    logic       done;
    err_t       err;
    logic       pend;
  } lz_result_t;

  class block_decode_model;
    bit [7:0]        hist [HIST_BYTES];
    dec_state_t      st;
    int unsigned     produced;
    int unsigned     size_goal;
    int unsigned     run_len;
    bit [3:0]        nibble;
    bit [15:0]       offset;
    bit              dropping;
    lz_result_t      cur;
    bit              setup;
    lz_result_t      decoded_q [$];
    longint unsigned stamp;
    int unsigned     items_taken;
    int unsigned     live_items;
    int unsigned     results_checked;
    int unsigned     block_ends;
    int unsigned     mismatches;

    function new();
      st = ST_TOKEN;
      produced = 0;
      size_goal = 0;
      run_len = 0;
      nibble = '0;
      offset = '0;
      dropping = 1'b0;
    endfunction

    function int unsigned backlog();
      return decoded_q.size();
    endfunction

    // End the block and return to token decoding
    function void finish_block(err_t e);
      cur.done = 1'b1;
      cur.err = e;
      st = ST_TOKEN;
      produced = 0;
      run_len = 0;
    endfunction

    // Drop the rest of the block unless the faulting byte was its last
    function void abort(err_t e, bit last);
      finish_block(e);
      if (!last) dropping = 1'b1;
    endfunction

    function void close_block();
      finish_block(produced == size_goal ? ERR_OK : ERR_MALFORMED);
    endfunction

    function void put_byte(bit [7:0] b);
      if (produced < HIST_BYTES) hist[produced] = b;
      cur.dv = 1'b1;
      cur.data = b;
      produced++;
    endfunction

    // Add an extension byte, saturating just past the largest block
    function void grow_len(bit [7:0] b);
      run_len += b;
      if (run_len > HIST_BYTES + 1) run_len = HIST_BYTES + 1;
    endfunction

    function void lit_len_done(bit last);
      if (run_len > size_goal - produced) begin
        abort(ERR_MALFORMED, last);
      end else if (run_len > 0) begin
        if (last) abort(ERR_MALFORMED, 1'b1);
        else st = ST_LIT;
      end else if (last) begin
        close_block();
      end else begin
        st = ST_OFFLO;
      end
    endfunction

    function void match_len_done(bit last);
      if (run_len + MATCH_MIN > size_goal - produced) begin
        abort(ERR_MALFORMED, last);
      end else begin
        run_len += MATCH_MIN;
        st = last ? ST_COPYEND : ST_COPY;
        setup = 1'b1;
      end
    endfunction

    // Emit one match byte from the history
    function void copy_one();
      int unsigned src;
      bit [7:0]    v;
      src = produced - offset;
      v = '0;
      if (src < HIST_BYTES) v = hist[src];
      put_byte(v);
      run_len--;
      if (run_len == 0) begin
        if (st == ST_COPYEND) close_block();
        else st = ST_TOKEN;
      end
    endfunction

    function void decode_byte(bit [7:0] b, bit last, bit [12:0] bsz);
      case (st)
        ST_TOKEN: begin
          if (produced == 0) size_goal = (bsz > HIST_BYTES) ? HIST_BYTES : bsz;
          nibble = b[3:0];
          run_len = b[7:4];
          if (b[7:4] == NIB_EXT) begin
            if (last) abort(ERR_MALFORMED, 1'b1);
            else st = ST_LITLEN;
          end else begin
            lit_len_done(last);
          end
        end
        ST_LITLEN: begin
          grow_len(b);
          if (b == BYTE_EXT) begin
            if (last) abort(ERR_MALFORMED, 1'b1);
          end else begin
            lit_len_done(last);
          end
        end
        ST_LIT: begin
          put_byte(b);
          run_len--;
          if (run_len == 0) begin
            if (last) close_block();
            else st = ST_OFFLO;
          end else if (last) begin
            abort(ERR_MALFORMED, 1'b1);
          end
        end
        ST_OFFLO: begin
          offset[7:0] = b;
          if (last) abort(ERR_MALFORMED, 1'b1);
          else st = ST_OFFHI;
        end
        ST_OFFHI: begin
          offset[15:8] = b;
          if (offset == 0 || offset > produced) begin
            abort(ERR_MALFORMED, last);
          end else if (nibble == NIB_EXT) begin
            run_len = NIB_EXT;
            if (last) abort(ERR_MALFORMED, 1'b1);
            else st = ST_MATLEN;
          end else begin
            run_len = nibble;
            match_len_done(last);
          end
        end
        ST_MATLEN: begin
          grow_len(b);
          if (b == BYTE_EXT) begin
            if (last) abort(ERR_MALFORMED, 1'b1);
          end else begin
            match_len_done(last);
          end
        end
        default: abort(ERR_BUSY, last);
      endcase
    endfunction

    // Note one accepted item and queue the result it causes, if any
    function void take_item(lz_item_t it);
      items_taken++;
      cur = '0;
      setup = 1'b0;
      if (dropping) begin
        if (!it.action && it.last) dropping = 1'b0;
        return;
      end
      if (it.action) begin
        if (st != ST_COPY && st != ST_COPYEND) return;
        copy_one();
      end else begin
        decode_byte(it.data, it.last, it.bsz);
      end
      live_items++;
      if (cur.dv || cur.done || setup) begin
        cur.pend = !dropping && (st == ST_COPY || st == ST_COPYEND);
        decoded_q.push_back(cur);
      end
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0d ns: %s mismatch, expected %0h, got %0h", stamp, field, want, got);
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_output(longint unsigned at, logic dv, logic [7:0] data,
                               logic done, logic [1:0] err, logic pend);
      lz_result_t want;
      stamp = at;
      results_checked++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0d ns: extra result, expected none, got dv=%0b data=%0h done=%0b err=%0d pend=%0b",
                   at, dv, data, done, err, pend);
        return;
      end
      want = decoded_q.pop_front();
      if (want.done) block_ends++;
      compare("data_valid", want.dv, dv);
      compare("out_data", want.data, data);
      compare("block_done", want.done, done);
      compare("error_code", want.err, err);
      compare("copy_pending", want.pend, pend);
    endfunction
  endclass

endpackage
`default_nettype wire

>>> tb/lz4_block_decoder_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ4 block decoder testbench
// Drives short directed streams, then random LZ4 blocks (mostly well formed,
// some damaged, overlong or pure noise) through the input channel, with
// random gaps on both channels, and checks every decoded result in order.
// ----------------------------------------------------------------------------
module lz4_block_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lz4d_pkg::*;
  import lz4d_tb_pkg::*;

  localparam int unsigned ITEM_GOAL   = 1800;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned SMALL_CAP   = 20;
  localparam int unsigned WIDE_CAP    = 300;
  localparam int unsigned LONG_BLOCK  = 1000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned src_idle_pct  = 36;
  int unsigned sink_idle_pct = 68;
  int unsigned stall_cycles  = 0;
  int unsigned n_clean, n_damaged, n_overrun, n_noise;
  lz_item_t    stim_q [$];
  lz_item_t    seen_in;

  block_decode_model db = new();

  lz4d_in_if  in_ch ();
  lz4d_out_if out_ch ();

  lz4_block_decoder DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Observe both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_in.action = in_ch.action;
      seen_in.data   = in_ch.in_byte;
      seen_in.last   = in_ch.last_byte;
      seen_in.bsz    = in_ch.block_out_size;
      db.take_item(seen_in);
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      db.check_output($time, out_ch.data_valid, out_ch.out_data, out_ch.block_done,
                      out_ch.error_code, out_ch.copy_pending);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no item accepted for %0d cycles", $time, stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned lesser(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [12:0] any_size();
    return 13'($urandom);
  endfunction

  function automatic logic [3:0] tok_nib(int unsigned v);
    return (v >= 15) ? NIB_EXT : 4'(v);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic lst, logic [12:0] bsz);
    lz_item_t it;
    it.action = 1'b0;
    it.data   = b;
    it.last   = lst;
    it.bsz    = bsz;
    stim_q.push_back(it);
  endfunction

  // Copy tick with random don't-care fields
  function automatic void add_tick();
    lz_item_t it;
    it.action = 1'b1;
    it.data   = 8'($urandom);
    it.last   = ($urandom_range(7) == 0);
    it.bsz    = any_size();
    stim_q.push_back(it);
  endfunction

  // Length extension: 255s while they fit, then the remainder
  function automatic void add_len_ext(int unsigned v);
    while (v >= 255) begin
      add_byte(BYTE_EXT, 1'b0, any_size());
      v -= 255;
    end
    add_byte(8'(v), 1'b0, any_size());
  endfunction

  // Encode one well-formed block of the given decoded size
  function automatic void build_block(int unsigned size, logic [12:0] bsz, int unsigned cap);
    int unsigned made, rem, lit, mat, i;
    logic [15:0] off;
    logic [12:0] tag;
    bit          first, closing;
    made = 0;
    first = 1'b1;
    do begin
      rem = size - made;
      tag = first ? bsz : any_size();
      first = 1'b0;
      closing = (rem < MATCH_MIN + 1) || ($urandom_range(5) == 0);
      if (closing) begin
        // final literal-only sequence, last flag on its final byte
        lit = rem;
        add_byte({tok_nib(lit), 4'($urandom)}, lit == 0, tag);
        if (lit >= 15) add_len_ext(lit - 15);
        for (i = 0; i < lit; i++) add_byte(8'($urandom), i == lit - 1, any_size());
      end else begin
        lit = $urandom_range(lesser(rem - MATCH_MIN, cap), made == 0 ? 1 : 0);
        mat = $urandom_range(lesser(rem - lit, cap + MATCH_MIN), MATCH_MIN);
        if ($urandom_range(3) == 0) off = 16'($urandom_range(lesser(made + lit, 4), 1));
        else off = 16'($urandom_range(made + lit, 1));
        add_byte({tok_nib(lit), tok_nib(mat - MATCH_MIN)}, 1'b0, tag);
        if (lit >= 15) add_len_ext(lit - 15);
        repeat (lit) add_byte(8'($urandom), 1'b0, any_size());
        add_byte(off[7:0], 1'b0, any_size());
        add_byte(off[15:8], 1'b0, any_size());
        if (mat - MATCH_MIN >= 15) add_len_ext(mat - MATCH_MIN - 15);
        // sometimes end the block on a match
        if (made + lit + mat == size && $urandom_range(1) == 1) begin
          stim_q[stim_q.size() - 1].last = 1'b1;
          closing = 1'b1;
        end
        repeat (mat) add_tick();
        made += lit + mat;
      end
    end while (!closing);
  endfunction

  // Offer one item, idling at random first; hold it until taken
  task automatic drive_item(lz_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= it.action;
    in_ch.in_byte        <= it.data;
    in_ch.last_byte      <= it.last;
    in_ch.block_out_size <= it.bsz;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_queue();
    lz_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      drive_item(it);
    end
  endtask

  // Hold the input until every expected result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (db.backlog() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned blocks, k, n, size, kind, start_live, progress;
    logic [12:0] bsz;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= 1'b0;
    in_ch.in_byte        <= '0;
    in_ch.last_byte      <= 1'b0;
    in_ch.block_out_size <= '0;
    n_clean = 0;
    n_damaged = 0;
    n_overrun = 0;
    n_noise = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty block, then an empty block that claims five bytes
    add_byte(8'h00, 1'b1, 13'd0);
    add_byte(8'h00, 1'b1, 13'd5);
    // Literal-only block with both byte extremes
    add_byte(8'h20, 1'b0, 13'd2);
    add_byte(8'h00, 1'b0, any_size());
    add_byte(8'hFF, 1'b1, any_size());
    // One literal, overlapping match at offset one, closed by an empty token
    add_byte(8'h10, 1'b0, 13'd5);
    add_byte(8'hA5, 1'b0, any_size());
    add_byte(8'h01, 1'b0, any_size());
    add_byte(8'h00, 1'b0, any_size());
    repeat (4) add_tick();
    add_byte(8'h00, 1'b1, any_size());
    // Zero offset aborts; drop the rest up to the last byte
    add_byte(8'h10, 1'b0, 13'd8);
    add_byte(8'h5A, 1'b0, any_size());
    add_byte(8'h00, 1'b0, any_size());
    add_byte(8'h00, 1'b0, any_size());
    add_byte(8'h33, 1'b1, any_size());
    // Tick with no copy pending
    add_tick();
    // Token announcing a length extension, marked last; size above the cap
    add_byte(8'hF0, 1'b1, 13'h1FFF);
    // Byte arriving while a copy is pending
    add_byte(8'h10, 1'b0, 13'd6);
    add_byte(8'h7E, 1'b0, any_size());
    add_byte(8'h01, 1'b0, any_size());
    add_byte(8'h00, 1'b0, any_size());
    add_byte(8'h00, 1'b1, any_size());
    send_queue();
    wait_drained();

    // Random blocks
    blocks = 0;
    start_live = db.live_items;
    progress = 0;
    while (progress < ITEM_GOAL) begin
      if (progress < ITEM_GOAL / 3) begin
        src_idle_pct = 36;
        sink_idle_pct = 68;
      end else if (progress < 2 * ITEM_GOAL / 3) begin
        src_idle_pct = 68;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      blocks++;
      kind = $urandom_range(99);
      if (blocks == 2) begin
        // one long block with long extensions
        build_block(LONG_BLOCK, 13'(LONG_BLOCK), 600);
        n_clean++;
      end else if (kind < 88) begin
        if ($urandom_range(11) == 0) size = $urandom_range(700, 200);
        else size = $urandom_range(40);
        bsz = 13'(size);
        if ($urandom_range(9) == 0) bsz = 13'(size + $urandom_range(3, 1));
        if ($urandom_range(19) == 0) bsz = any_size();
        build_block(size, bsz, size > 64 ? WIDE_CAP : SMALL_CAP);
        if (kind < 70) begin
          n_clean++;
        end else begin
          // damage it: cut short, corrupt one item, or lose one item
          n_damaged++;
          k = $urandom_range(stim_q.size() - 1);
          case ($urandom_range(2))
            0: begin
              stim_q[k].action = 1'b0;
              stim_q[k].last = 1'b1;
              while (stim_q.size() > k + 1) void'(stim_q.pop_back());
            end
            1: begin
              stim_q[k].action = 1'b0;
              stim_q[k].data = 8'($urandom);
            end
            default: stim_q.delete(k);
          endcase
        end
      end else if (kind < 94) begin
        // overlong literal run against a small size
        n_overrun++;
        add_byte({NIB_EXT, 4'($urandom)}, 1'b0, 13'($urandom_range(64)));
        n = $urandom_range(20);
        repeat (n) add_byte(BYTE_EXT, 1'b0, any_size());
        add_byte(8'($urandom_range(254)), 1'b1, any_size());
      end else begin
        // random items, then a last byte to resync
        n_noise++;
        n = $urandom_range(24, 3);
        repeat (n) begin
          if ($urandom_range(1) == 1) add_tick();
          else add_byte(8'($urandom), $urandom_range(9) == 0, any_size());
        end
        add_byte(8'($urandom), 1'b1, any_size());
      end
      send_queue();
      if (blocks % 9 == 0) wait_drained();
      progress = db.live_items - start_live;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d random blocks: %0d well-formed, %0d damaged, %0d overlong, %0d noise.",
             blocks, n_clean, n_damaged, n_overrun, n_noise);
    $display("%0d items taken, %0d results compared, %0d block ends seen, %0d mismatches.",
             db.items_taken, db.results_checked, db.block_ends, db.mismatches);
    if (db.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/lz4d_pkg.sv
rtl/lz4d_if.sv
rtl/lz4d_hist.sv
rtl/lz4d_parse.sv
rtl/lz4_block_decoder.sv
tb/lz4d_tb_pkg.sv
tb/lz4_block_decoder_tb.sv
